// ===== src/assert_macros.svh =====
// Assertion macros shared by the rotation center check RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define PRC_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define PRC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/prc_pkg.sv =====
// Shared types, constants and tables of the rotation center check.
package prc_pkg;

    localparam int RED_W        = 43;
    localparam int REDUCE_STEPS = 8;
    localparam int Z_W          = 34;
    localparam int XY_W         = 34;
    localparam int A_W          = 35;
    localparam int DET_W        = 36;
    localparam int PROD_W       = 66;
    localparam int NUM_W        = 64;
    localparam int QUO_W        = 32;
    localparam int DEN_W        = 34;

    localparam logic signed [RED_W-1:0] PI_Q30      = 43'sd3373259426;
    localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 43'sd1686629713;
    localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;
    localparam logic signed [A_W-1:0]   ONE_Q30     = 35'sd1073741824;
    localparam logic signed [DET_W-1:0] DET_LIMIT   = 36'sd107375;

    localparam logic CFG_FORWARD = 1'b0;
    localparam logic CFG_LATERAL = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_ACCEPTED      = 3'd0,
        VERDICT_NOT_CONVERGED = 3'd1,
        VERDICT_SINGULAR      = 3'd2,
        VERDICT_OVERFLOW      = 3'd3,
        VERDICT_IMPLAUSIBLE   = 3'd4
    } verdict_t;

    // Translation and convergence flag carried alongside the angle path.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               conv;
    } side_t;

    // Arctangent of 2^-i in Q30; from 2^-10 down the angle is taken equal to its tangent.
    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = 34'sd843314857;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043837;
            3:       v = 34'sd133525159;
            4:       v = 34'sd67021687;
            5:       v = 34'sd33543516;
            6:       v = 34'sd16775851;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194283;
            9:       v = 34'sd2097149;
            default: v = {{(Z_W-1){1'b0}}, 1'b1} << (30 - i);
        endcase
        return v;
    endfunction

    // Full turn scaled by 2^j, used by the binary angle reduction.
    function automatic logic signed [RED_W-1:0] reduce_step(input int j);
        return (PI_Q30 <<< 1) <<< j;
    endfunction

endpackage

// ===== src/prc_angle_reduce.sv =====
// Angle widening, reduction into one turn and fold into the right half plane.
module prc_angle_reduce #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [18:0]                turn_angle,
    input  prc_pkg::side_t                    in_side,
    output logic                              out_valid,
    output logic signed [prc_pkg::Z_W-1:0]    z_out,
    output logic                              flip_out,
    output prc_pkg::side_t                    out_side
);

    localparam int SHIFT = 30 - FRACTION_BITS;
    localparam int N     = prc_pkg::REDUCE_STEPS;

    logic                              valid_reg [0:N];
    logic signed [prc_pkg::RED_W-1:0]  m_reg     [0:N];
    logic                              neg_reg   [0:N];
    prc_pkg::side_t                    side_reg  [0:N];

    logic signed [prc_pkg::RED_W-1:0]  wide_next;
    logic signed [prc_pkg::RED_W-1:0]  fold_next;
    logic                              flip_next;
    logic                              valid_out_reg;
    logic signed [prc_pkg::Z_W-1:0]    z_reg;
    logic                              flip_reg;
    prc_pkg::side_t                    side_out_reg;

    // The reduction works on the magnitude; the sign is put back at the fold.
    assign wide_next = prc_pkg::RED_W'(turn_angle) <<< SHIFT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
        if (en) begin
            m_reg[0]    <= turn_angle[18] ? -wide_next : wide_next;
            neg_reg[0]  <= turn_angle[18];
            side_reg[0] <= in_side;
        end
    end

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_step
            localparam logic signed [prc_pkg::RED_W-1:0] STEP =
                prc_pkg::reduce_step(N - 1 - k);
            localparam logic signed [prc_pkg::RED_W-1:0] LIMIT = STEP - prc_pkg::PI_Q30;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k+1] <= 1'b0;
                end else if (en) begin
                    valid_reg[k+1] <= valid_reg[k];
                end
                if (en) begin
                    m_reg[k+1]    <= (m_reg[k] > LIMIT) ? m_reg[k] - STEP : m_reg[k];
                    neg_reg[k+1]  <= neg_reg[k];
                    side_reg[k+1] <= side_reg[k];
                end
            end
        end
    endgenerate

    always_comb begin
        fold_next = m_reg[N];
        flip_next = 1'b0;
        if (m_reg[N] > prc_pkg::HALF_PI_Q30) begin
            fold_next = m_reg[N] - prc_pkg::PI_Q30;
            flip_next = 1'b1;
        end else if (m_reg[N] < -prc_pkg::HALF_PI_Q30) begin
            fold_next = m_reg[N] + prc_pkg::PI_Q30;
            flip_next = 1'b1;
        end
        if (neg_reg[N]) begin
            fold_next = -fold_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out_reg <= 1'b0;
        end else if (en) begin
            valid_out_reg <= valid_reg[N];
        end
        if (en) begin
            z_reg        <= fold_next[prc_pkg::Z_W-1:0];
            flip_reg     <= flip_next;
            side_out_reg <= side_reg[N];
        end
    end

    assign out_valid = valid_out_reg;
    assign z_out     = z_reg;
    assign flip_out  = flip_reg;
    assign out_side  = side_out_reg;

endmodule

// ===== src/prc_cordic.sv =====
// Rotation mode CORDIC, one micro-rotation per pipeline stage.
module prc_cordic #(
    parameter int STAGES = 18
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [prc_pkg::Z_W-1:0]    z_in,
    input  logic                              flip_in,
    input  prc_pkg::side_t                    in_side,
    output logic                              out_valid,
    output logic signed [prc_pkg::XY_W-1:0]   x_out,
    output logic signed [prc_pkg::XY_W-1:0]   y_out,
    output logic                              flip_out,
    output prc_pkg::side_t                    out_side
);

    logic                              valid_reg [0:STAGES-1];
    logic signed [prc_pkg::XY_W-1:0]   x_reg     [0:STAGES-1];
    logic signed [prc_pkg::XY_W-1:0]   y_reg     [0:STAGES-1];
    logic signed [prc_pkg::Z_W-1:0]    z_reg     [0:STAGES-1];
    logic                              flip_reg  [0:STAGES-1];
    prc_pkg::side_t                    side_reg  [0:STAGES-1];

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            localparam logic signed [prc_pkg::Z_W-1:0] ATAN = prc_pkg::atan_entry(k);
            logic                            v_cur;
            logic signed [prc_pkg::XY_W-1:0] x_cur;
            logic signed [prc_pkg::XY_W-1:0] y_cur;
            logic signed [prc_pkg::Z_W-1:0]  z_cur;
            logic                            f_cur;
            prc_pkg::side_t                  s_cur;

            if (k == 0) begin : g_first
                assign v_cur = in_valid;
                assign x_cur = prc_pkg::GAIN_Q30;
                assign y_cur = '0;
                assign z_cur = z_in;
                assign f_cur = flip_in;
                assign s_cur = in_side;
            end else begin : g_next
                assign v_cur = valid_reg[k-1];
                assign x_cur = x_reg[k-1];
                assign y_cur = y_reg[k-1];
                assign z_cur = z_reg[k-1];
                assign f_cur = flip_reg[k-1];
                assign s_cur = side_reg[k-1];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= v_cur;
                end
                if (en) begin
                    if (!z_cur[prc_pkg::Z_W-1]) begin
                        x_reg[k] <= x_cur - (y_cur >>> k);
                        y_reg[k] <= y_cur + (x_cur >>> k);
                        z_reg[k] <= z_cur - ATAN;
                    end else begin
                        x_reg[k] <= x_cur + (y_cur >>> k);
                        y_reg[k] <= y_cur - (x_cur >>> k);
                        z_reg[k] <= z_cur + ATAN;
                    end
                    flip_reg[k] <= f_cur;
                    side_reg[k] <= s_cur;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign x_out     = x_reg[STAGES-1];
    assign y_out     = y_reg[STAGES-1];
    assign flip_out  = flip_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== src/prc_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module prc_divider #(
    parameter int TAG_W = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [prc_pkg::NUM_W-1:0]         num,
    input  logic [prc_pkg::DEN_W-1:0]         den,
    input  logic [TAG_W-1:0]                  tag_in,
    output logic                              out_valid,
    output logic [prc_pkg::QUO_W-1:0]         quo,
    output logic                              ovf,
    output logic [TAG_W-1:0]                  tag_out
);

    localparam int QW = prc_pkg::QUO_W;
    localparam int DW = prc_pkg::DEN_W;

    logic             valid_reg [0:QW];
    logic [DW-1:0]    rem_reg   [0:QW];
    logic [QW-1:0]    low_reg   [0:QW];
    logic [DW-1:0]    den_reg   [0:QW];
    logic             ovf_reg   [0:QW];
    logic [TAG_W-1:0] tag_reg   [0:QW];

    // A quotient of 2^32 or more shows as a high half not below the divisor.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
        if (en) begin
            rem_reg[0] <= DW'(num[prc_pkg::NUM_W-1:QW]);
            low_reg[0] <= num[QW-1:0];
            den_reg[0] <= den;
            ovf_reg[0] <= DW'(num[prc_pkg::NUM_W-1:QW]) >= den;
            tag_reg[0] <= tag_in;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++) begin : g_bit
            logic [DW:0]   trial_next;
            logic          fits_next;
            logic [DW-1:0] rem_next;

            assign trial_next = {rem_reg[k-1], low_reg[k-1][QW-1]};
            assign fits_next  = trial_next >= {1'b0, den_reg[k-1]};
            assign rem_next   = fits_next ? DW'(trial_next - {1'b0, den_reg[k-1]})
                                          : trial_next[DW-1:0];

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
                if (en) begin
                    rem_reg[k] <= rem_next;
                    low_reg[k] <= {low_reg[k-1][QW-2:0], fits_next};
                    den_reg[k] <= den_reg[k-1];
                    ovf_reg[k] <= ovf_reg[k-1];
                    tag_reg[k] <= tag_reg[k-1];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QW];
    assign quo       = low_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign tag_out   = tag_reg[QW];

endmodule

// ===== src/planar_rotation_center_check_top.sv =====
// Rotation center check: fixed point of a planar rigid transform, with plausibility verdict.
//
// Each request carries one planar rigid transform (shift x, shift y in signed Q16.16,
// yaw in signed Q3.16 radians) and a converged flag; each one yields exactly one result
// with the rotation center in Q16.16 and a verdict code. The block is a fully pipelined
// datapath that accepts one request in every clock cycle unless a result is stalled. Its
// stages run in order: angle reduction and fold, the CORDIC micro-rotations, the cosine
// term, the four products, the numerators, their rounding, the two parallel bit-per-stage
// dividers and one output register. A stalled result holds the whole pipeline, so
// s_tready follows m_tready whenever the output register is full; nothing is dropped or
// repeated. The yaw is reduced modulo a full turn for any 19-bit pattern. The two limit
// registers are written through the cfg port and must only change while no request is
// in flight.
module planar_rotation_center_check_top #(
    parameter int FRACTION_BITS = 16,
    parameter int CORDIC_STAGES = 18
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // [31:0] shift_x, [63:32] shift_y, [82:64] turn_angle
    input  logic [0:0]  s_tuser,   // [0] match_converged
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] center_x, [63:32] center_y
    output logic [2:0]  m_tuser,   // [2:0] verdict
    // Limit register write port.
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    localparam int XY_W   = prc_pkg::XY_W;
    localparam int A_W    = prc_pkg::A_W;
    localparam int DET_W  = prc_pkg::DET_W;
    localparam int PROD_W = prc_pkg::PROD_W;
    localparam int NUM_W  = prc_pkg::NUM_W;
    localparam int QUO_W  = prc_pkg::QUO_W;
    localparam int DEN_W  = prc_pkg::DEN_W;

    // The whole pipeline advances together unless a finished result waits.
    logic en;

    logic [30:0] max_fwd_reg;
    logic [30:0] max_lat_reg;

    prc_pkg::side_t in_side;

    logic                         red_valid;
    logic signed [prc_pkg::Z_W-1:0] red_z;
    logic                         red_flip;
    prc_pkg::side_t               red_side;

    logic                         cor_valid;
    logic signed [XY_W-1:0]       cor_x;
    logic signed [XY_W-1:0]       cor_y;
    logic                         cor_flip;
    prc_pkg::side_t               cor_side;

    // Cosine term, sine and determinant.
    logic                         p0_valid_reg;
    logic signed [A_W-1:0]        p0_a_reg;
    logic signed [XY_W-1:0]       p0_s_reg;
    logic signed [DET_W-1:0]      p0_det_reg;
    logic                         p0_sing_reg;
    prc_pkg::side_t               p0_side_reg;
    logic signed [XY_W-1:0]       p0_c_next;
    logic signed [A_W-1:0]        p0_a_next;
    logic signed [DET_W-1:0]      p0_det_next;

    // Four products.
    logic                         p1_valid_reg;
    logic signed [PROD_W-1:0]     p1_ax_reg;
    logic signed [PROD_W-1:0]     p1_sy_reg;
    logic signed [PROD_W-1:0]     p1_sx_reg;
    logic signed [PROD_W-1:0]     p1_ay_reg;
    logic signed [DET_W-1:0]      p1_det_reg;
    logic                         p1_sing_reg;
    logic                         p1_conv_reg;

    // Numerators.
    logic                         p2_valid_reg;
    logic signed [PROD_W-1:0]     p2_nx_reg;
    logic signed [PROD_W-1:0]     p2_ny_reg;
    logic signed [DET_W-1:0]      p2_det_reg;
    logic                         p2_sing_reg;
    logic                         p2_conv_reg;

    // Rounded magnitudes ready for division.
    logic                         p3_valid_reg;
    logic [NUM_W-1:0]             p3_num_x_reg;
    logic [NUM_W-1:0]             p3_num_y_reg;
    logic                         p3_neg_x_reg;
    logic                         p3_neg_y_reg;
    logic [DEN_W-1:0]             p3_den_reg;
    logic                         p3_sing_reg;
    logic                         p3_conv_reg;
    logic signed [PROD_W-1:0]     p3_half_next;

    logic                         div_x_valid;
    logic [QUO_W-1:0]             div_x_quo;
    logic                         div_x_ovf;
    logic [2:0]                   div_x_tag;
    logic                         div_y_valid;
    logic [QUO_W-1:0]             div_y_quo;
    logic                         div_y_ovf;
    logic [0:0]                   div_y_tag;

    logic                         out_valid_reg;
    logic [31:0]                  cx_reg;
    logic [31:0]                  cy_reg;
    prc_pkg::verdict_t            verdict_reg;
    logic [31:0]                  cx_next;
    logic [31:0]                  cy_next;
    prc_pkg::verdict_t            verdict_next;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_fwd_reg <= 31'd131072;
            max_lat_reg <= 31'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_index[0])
                prc_pkg::CFG_FORWARD: max_fwd_reg <= cfg_data;
                prc_pkg::CFG_LATERAL: max_lat_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_side.x    = $signed(s_tdata[31:0]);
    assign in_side.y    = $signed(s_tdata[63:32]);
    assign in_side.conv = s_tuser[0];

    prc_angle_reduce #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .turn_angle($signed(s_tdata[82:64])),
        .in_side   (in_side),
        .out_valid (red_valid),
        .z_out     (red_z),
        .flip_out  (red_flip),
        .out_side  (red_side)
    );

    prc_cordic #(
        .STAGES(CORDIC_STAGES)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (red_valid),
        .z_in     (red_z),
        .flip_in  (red_flip),
        .in_side  (red_side),
        .out_valid(cor_valid),
        .x_out    (cor_x),
        .y_out    (cor_y),
        .flip_out (cor_flip),
        .out_side (cor_side)
    );

    // A half-turn fold negates both cosine and sine.
    always_comb begin
        p0_c_next   = cor_flip ? -cor_x : cor_x;
        p0_a_next   = prc_pkg::ONE_Q30 - A_W'(p0_c_next);
        p0_det_next = DET_W'(p0_a_next) <<< 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p0_valid_reg <= cor_valid;
            p1_valid_reg <= p0_valid_reg;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
        if (en) begin
            p0_a_reg    <= p0_a_next;
            p0_s_reg    <= cor_flip ? -cor_y : cor_y;
            p0_det_reg  <= p0_det_next;
            p0_sing_reg <= p0_det_next < prc_pkg::DET_LIMIT;
            p0_side_reg <= cor_side;

            p1_ax_reg   <= PROD_W'(p0_a_reg) * PROD_W'($signed(p0_side_reg.x));
            p1_sy_reg   <= PROD_W'(p0_s_reg) * PROD_W'($signed(p0_side_reg.y));
            p1_sx_reg   <= PROD_W'(p0_s_reg) * PROD_W'($signed(p0_side_reg.x));
            p1_ay_reg   <= PROD_W'(p0_a_reg) * PROD_W'($signed(p0_side_reg.y));
            p1_det_reg  <= p0_det_reg;
            p1_sing_reg <= p0_sing_reg;
            p1_conv_reg <= p0_side_reg.conv;

            p2_nx_reg   <= p1_ax_reg - p1_sy_reg;
            p2_ny_reg   <= p1_sx_reg + p1_ay_reg;
            p2_det_reg  <= p1_det_reg;
            p2_sing_reg <= p1_sing_reg;
            p2_conv_reg <= p1_conv_reg;

            // Magnitude plus half the divisor rounds the quotient to nearest, ties away from zero.
            p3_num_x_reg <= p2_nx_reg[PROD_W-1] ? NUM_W'(p3_half_next - p2_nx_reg)
                                                : NUM_W'(p2_nx_reg + p3_half_next);
            p3_num_y_reg <= p2_ny_reg[PROD_W-1] ? NUM_W'(p3_half_next - p2_ny_reg)
                                                : NUM_W'(p2_ny_reg + p3_half_next);
            p3_neg_x_reg <= p2_nx_reg[PROD_W-1];
            p3_neg_y_reg <= p2_ny_reg[PROD_W-1];
            p3_den_reg   <= p2_det_reg[DEN_W-1:0];
            p3_sing_reg  <= p2_sing_reg;
            p3_conv_reg  <= p2_conv_reg;
        end
    end

    assign p3_half_next = PROD_W'(p2_det_reg >>> 1);

    prc_divider #(
        .TAG_W(3)
    ) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (p3_valid_reg),
        .num      (p3_num_x_reg),
        .den      (p3_den_reg),
        .tag_in   ({p3_conv_reg, p3_sing_reg, p3_neg_x_reg}),
        .out_valid(div_x_valid),
        .quo      (div_x_quo),
        .ovf      (div_x_ovf),
        .tag_out  (div_x_tag)
    );

    prc_divider #(
        .TAG_W(1)
    ) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (p3_valid_reg),
        .num      (p3_num_y_reg),
        .den      (p3_den_reg),
        .tag_in   (p3_neg_y_reg),
        .out_valid(div_y_valid),
        .quo      (div_y_quo),
        .ovf      (div_y_ovf),
        .tag_out  (div_y_tag)
    );

    // A negative quotient may reach -2^31; a positive one must stay below 2^31.
    always_comb begin
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
        logic implausible;
        neg_x = div_x_tag[0];
        neg_y = div_y_tag[0];
        ovf_x = div_x_ovf || (neg_x ? (div_x_quo[QUO_W-1] && (div_x_quo[QUO_W-2:0] != '0))
                                    : div_x_quo[QUO_W-1]);
        ovf_y = div_y_ovf || (neg_y ? (div_y_quo[QUO_W-1] && (div_y_quo[QUO_W-2:0] != '0))
                                    : div_y_quo[QUO_W-1]);
        // The lateral limit applies to the magnitude, which is the quotient itself.
        implausible = (neg_x && (div_x_quo != '0)) ||
                      (!neg_x && (div_x_quo > {1'b0, max_fwd_reg})) ||
                      (div_y_quo > {1'b0, max_lat_reg});
        cx_next      = '0;
        cy_next      = '0;
        verdict_next = prc_pkg::VERDICT_ACCEPTED;
        if (!div_x_tag[2]) begin
            verdict_next = prc_pkg::VERDICT_NOT_CONVERGED;
        end else if (div_x_tag[1]) begin
            verdict_next = prc_pkg::VERDICT_SINGULAR;
        end else if (ovf_x || ovf_y) begin
            verdict_next = prc_pkg::VERDICT_OVERFLOW;
        end else begin
            cx_next = neg_x ? -div_x_quo : div_x_quo;
            cy_next = neg_y ? -div_y_quo : div_y_quo;
            if (implausible) begin
                verdict_next = prc_pkg::VERDICT_IMPLAUSIBLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= div_x_valid;
        end
        if (en) begin
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            verdict_reg <= verdict_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {cy_reg, cx_reg};
    assign m_tuser  = verdict_reg;

`include "assert_macros.svh"

    `PRC_ASSERT_ALWAYS(a_div_lockstep, aclk, aresetn, div_x_valid == div_y_valid, "dividers out of step")
    `PRC_ASSERT_IMPL(a_accept_nonneg, aclk, aresetn, m_tvalid && (m_tuser == prc_pkg::VERDICT_ACCEPTED), !m_tdata[31], "accepted center has negative x")
    `PRC_ASSERT_IMPL(a_reject_zero, aclk, aresetn, m_tvalid && ((m_tuser == prc_pkg::VERDICT_NOT_CONVERGED) || (m_tuser == prc_pkg::VERDICT_SINGULAR) || (m_tuser == prc_pkg::VERDICT_OVERFLOW)), m_tdata == '0, "rejected result carries nonzero center")

endmodule
